/* rtl/dhse_pkg.sv */
// ----------------------------------------------------------------------------
// dhse_pkg
// Shared codes, field widths and controller/datapath interface structs for
// the double hashing key set engine.
// ----------------------------------------------------------------------------
package dhse_pkg;

    localparam int REQ_W     = 2;
    localparam int KEY_IN_W  = 32;
    localparam int CNT_OUT_W = 10;
    localparam int ST_W      = 2;

    localparam logic [REQ_W-1:0] REQ_ADD      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CONTAINS = 2'd2;

    localparam logic [ST_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [ST_W-1:0] ST_USED  = 2'd1;
    localparam logic [ST_W-1:0] ST_TOMB  = 2'd2;

    typedef struct packed {
        logic clear;
        logic load;
        logic div_step;
        logic hash;
        logic step_set;
        logic rd;
        logic eval;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic req_ok;
        logic probe_end;
        logic out_busy;
    } t_sts;

endpackage

/* rtl/double_hash_set_engine_unit.sv */
// probing: none for an unused request type; a second division reduces the step
//   when SECOND_PRIME >= 2*TABLE_SIZE
// requests: one at a time, the next taken only after the result commits, paced by
//   the reciprocal hash and the read/evaluate loop on the slot memory
// reset: synchronous, active low; a clearing pass marks every slot empty, input
//   stalled until it ends
// ----------------------------------------------------------------------------
// double_hash_set_engine_unit
// Open-addressed key set with double hashing: add, remove and membership test,
// tombstones on remove reused by add.
// ----------------------------------------------------------------------------
module double_hash_set_engine_unit #(
    parameter int TABLE_SIZE   = 1021,
    parameter int SECOND_PRIME = 97,
    parameter int KEY_WIDTH    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [dhse_pkg::REQ_W-1:0]      i_req_type,
    input  logic [dhse_pkg::KEY_IN_W-1:0]   i_key,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic                            o_inserted,
    output logic                            o_table_full,
    output logic [dhse_pkg::CNT_OUT_W-1:0]  o_entry_count,
    output logic                            o_set_empty
);
    import dhse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dhse_ctrl #(
        .TABLE_SIZE   (TABLE_SIZE),
        .SECOND_PRIME (SECOND_PRIME)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    dhse_dp #(
        .TABLE_SIZE   (TABLE_SIZE),
        .SECOND_PRIME (SECOND_PRIME),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_inserted    (o_inserted),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count),
        .o_set_empty   (o_set_empty)
    );

endmodule

/* rtl/dhse_dp.sv */
// ----------------------------------------------------------------------------
// dhse_dp
// Datapath: reciprocal hash reduction, probe position and step, slot memory,
// tombstone tracking, entry count and the result register.
// ----------------------------------------------------------------------------
module dhse_dp #(
    parameter int TABLE_SIZE   = 1021,
    parameter int SECOND_PRIME = 97,
    parameter int KEY_WIDTH    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dhse_pkg::t_cmd                  i_cmd,
    output dhse_pkg::t_sts                  o_sts,
    input  logic [dhse_pkg::REQ_W-1:0]      i_req_type,
    input  logic [dhse_pkg::KEY_IN_W-1:0]   i_key,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic                            o_inserted,
    output logic                            o_table_full,
    output logic [dhse_pkg::CNT_OUT_W-1:0]  o_entry_count,
    output logic                            o_set_empty
);
    import dhse_pkg::*;

    localparam int TW  = $clog2(TABLE_SIZE);
    localparam int PW  = $clog2(SECOND_PRIME);
    localparam int SPW = $clog2(SECOND_PRIME + 1);
    localparam int CW  = $clog2(TABLE_SIZE + 1);
    localparam int KEW = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam int XW  = (KEW > SPW) ? KEW : SPW;
    localparam int RW  = ((XW > TW) ? XW : TW) + 1;
    localparam int MW  = (SPW > TW + 1) ? SPW : TW + 1;
    localparam int WW  = KEY_WIDTH + ST_W;

    localparam logic [XW-1:0] RCP_T = XW'((64'd1 << XW) / 64'(TABLE_SIZE));
    localparam logic [XW-1:0] RCP_P = XW'((64'd1 << XW) / 64'(SECOND_PRIME));

    logic [WW-1:0]        r_mem [TABLE_SIZE];
    logic [WW-1:0]        r_rd;

    logic [REQ_W-1:0]     r_req;
    logic [KEY_WIDTH-1:0] r_key;
    logic [XW-1:0]        r_div;
    logic [1:0]           r_div_cnt;
    logic [2*XW-1:0]      r_prod_t;
    logic [2*XW-1:0]      r_prod_p;
    logic [XW-1:0]        r_qm_t;
    logic [XW-1:0]        r_qm_p;
    logic [TW-1:0]        r_rem_t;
    logic [PW-1:0]        r_rem_p;
    logic [TW-1:0]        r_pos;
    logic [TW-1:0]        r_step;
    logic [CW-1:0]        r_cnt;
    logic                 r_tomb_v;
    logic [TW-1:0]        r_tomb;
    logic                 r_found;
    logic [TW-1:0]        r_tgt;
    logic                 r_tgt_v;
    logic [TW-1:0]        r_clr;
    logic [CW-1:0]        r_held;
    logic                 r_o_valid;
    logic                 r_o_found;
    logic                 r_o_ins;
    logic                 r_o_full;
    logic [CNT_OUT_W-1:0] r_o_cnt;
    logic                 r_o_empty;

    logic [63:0]          key_ext;
    logic [KEY_WIDTH-1:0] key_in;
    logic [RW-1:0]        rem_t_raw;
    logic [TW-1:0]        n_rem_t;
    logic [RW-1:0]        rem_p_raw;
    logic [PW-1:0]        n_rem_p;
    logic [SPW-1:0]       step_raw;
    logic [MW-1:0]        step_ext;
    logic [TW-1:0]        step_short;
    logic [ST_W-1:0]      rd_st;
    logic [KEY_WIDTH-1:0] rd_key;
    logic                 is_empty;
    logic                 is_hit;
    logic                 is_tomb;
    logic                 is_last;
    logic [TW:0]          pos_sum;
    logic [TW-1:0]        n_pos;
    logic                 req_ok;
    logic                 do_ins;
    logic                 do_del;
    logic                 do_full;
    logic [CW-1:0]        n_held;
    logic                 wr_en;
    logic [TW-1:0]        wr_addr;
    logic [WW-1:0]        wr_data;

    // key taken to the configured width
    assign key_ext = 64'(i_key);
    assign key_in  = key_ext[KEY_WIDTH-1:0];

    // reciprocal reduction for both moduli
    assign rem_t_raw = RW'(r_div) - RW'(r_qm_t);
    assign n_rem_t   = (rem_t_raw >= RW'(TABLE_SIZE)) ? TW'(rem_t_raw - RW'(TABLE_SIZE))
                                                      : TW'(rem_t_raw);
    assign rem_p_raw = RW'(r_div) - RW'(r_qm_p);
    assign n_rem_p   = (rem_p_raw >= RW'(SECOND_PRIME)) ? PW'(rem_p_raw - RW'(SECOND_PRIME))
                                                        : PW'(rem_p_raw);

    assign step_raw   = SPW'(SECOND_PRIME) - SPW'(r_rem_p);
    assign step_ext   = MW'(step_raw);
    assign step_short = (step_ext >= MW'(TABLE_SIZE)) ? TW'(step_ext - MW'(TABLE_SIZE))
                                                      : TW'(step_ext);

    // probe evaluation
    assign rd_st    = r_rd[ST_W-1:0];
    assign rd_key   = r_rd[WW-1:ST_W];
    assign is_empty = (rd_st == ST_EMPTY);
    assign is_hit   = (rd_st == ST_USED) && (rd_key == r_key);
    assign is_tomb  = !is_empty && (rd_st != ST_USED);
    assign is_last  = (r_cnt == CW'(TABLE_SIZE - 1));
    assign pos_sum  = {1'b0, r_pos} + {1'b0, r_step};
    assign n_pos    = (pos_sum >= (TW+1)'(TABLE_SIZE)) ? TW'(pos_sum - (TW+1)'(TABLE_SIZE))
                                                       : TW'(pos_sum);

    // commit
    assign req_ok  = (r_req == REQ_ADD) || (r_req == REQ_REMOVE) || (r_req == REQ_CONTAINS);
    assign do_ins  = (r_req == REQ_ADD) && !r_found && r_tgt_v;
    assign do_full = (r_req == REQ_ADD) && !r_found && !r_tgt_v;
    assign do_del  = (r_req == REQ_REMOVE) && r_found;

    always_comb begin
        n_held = r_held;
        if (do_ins) begin
            n_held = r_held + CW'(1);
        end else if (do_del && (r_held != '0)) begin
            n_held = r_held - CW'(1);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_tgt;
        wr_data = {r_key, ST_USED};
        if (i_cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = {{KEY_WIDTH{1'b0}}, ST_EMPTY};
        end else if (i_cmd.commit && (do_ins || do_del)) begin
            wr_en   = 1'b1;
            wr_data = {r_key, do_ins ? ST_USED : ST_TOMB};
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_key     <= key_in;
            r_div     <= XW'(key_in);
            r_div_cnt <= 2'd2;
            r_cnt     <= '0;
            r_tomb_v  <= 1'b0;
            r_found   <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - 2'd1;
            r_prod_t  <= (2*XW)'(r_div) * (2*XW)'(RCP_T);
            r_prod_p  <= (2*XW)'(r_div) * (2*XW)'(RCP_P);
            r_qm_t    <= r_prod_t[2*XW-1:XW] * XW'(TABLE_SIZE);
            r_qm_p    <= r_prod_p[2*XW-1:XW] * XW'(SECOND_PRIME);
            if (r_div_cnt == 2'd0) begin
                r_rem_t <= n_rem_t;
                r_rem_p <= n_rem_p;
            end
        end
        if (i_cmd.hash) begin
            r_pos     <= r_rem_t;
            r_step    <= step_short;
            r_div     <= XW'(step_raw);
            r_div_cnt <= 2'd2;
        end
        if (i_cmd.step_set) begin
            r_step <= r_rem_t;
        end
        if (i_cmd.eval) begin
            r_found <= is_hit;
            r_tgt   <= (is_hit || !r_tomb_v) ? r_pos : r_tomb;
            r_tgt_v <= is_empty || r_tomb_v || is_tomb;
            if (is_tomb && !r_tomb_v) begin
                r_tomb_v <= 1'b1;
                r_tomb   <= r_pos;
            end
            r_pos <= n_pos;
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.commit) begin
            r_o_found <= r_found;
            r_o_ins   <= do_ins;
            r_o_full  <= do_full;
            r_o_cnt   <= CNT_OUT_W'(n_held);
            r_o_empty <= (n_held == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_held    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + TW'(1);
            end
            if (i_cmd.commit) begin
                r_held    <= n_held;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_clr == TW'(TABLE_SIZE - 1));
    assign o_sts.div_last   = (r_div_cnt == 2'd0);
    assign o_sts.req_ok     = req_ok;
    assign o_sts.probe_end  = is_empty || is_hit || is_last;
    assign o_sts.out_busy   = r_o_valid && i_stall;

    assign o_valid       = r_o_valid;
    assign o_found       = r_o_found;
    assign o_inserted    = r_o_ins;
    assign o_table_full  = r_o_full;
    assign o_entry_count = r_o_cnt;
    assign o_set_empty   = r_o_empty;

endmodule

/* rtl/dhse_ctrl.sv */
// ----------------------------------------------------------------------------
// dhse_ctrl
// Sequencer: memory clearing pass, hash division, probe read/evaluate loop
// and result commit.
// ----------------------------------------------------------------------------
module dhse_ctrl #(
    parameter int TABLE_SIZE   = 1021,
    parameter int SECOND_PRIME = 97
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output dhse_pkg::t_cmd o_cmd,
    input  dhse_pkg::t_sts i_sts
);
    import dhse_pkg::*;

    localparam logic STEP_DIV = (SECOND_PRIME >= 2 * TABLE_SIZE);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_HASH   = 9'b000001000,
        S_DIV2   = 9'b000010000,
        S_STEP   = 9'b000100000,
        S_READ   = 9'b001000000,
        S_EVAL   = 9'b010000000,
        S_COMMIT = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                if (!i_sts.req_ok) begin
                    n_state = S_COMMIT;
                end else if (STEP_DIV) begin
                    n_state = S_DIV2;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step_set = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.probe_end ? S_COMMIT : S_READ;
            end
            S_COMMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double hashing key set engine. Add, remove and
// membership requests go in through the valid/stall port. A scoreboard keeps
// its own copy of the probed table and checks every result field in order.
// Traffic starts with directed collision and tombstone cases. It then mixes
// requests over a small key pool, fills the table until adds report full, and
// ends with removes, lookups and adds on the crowded table. Both sides idle at
// random, and a long receiver hold-off lets the request port back up.
// ----------------------------------------------------------------------------
module tb;
    import dhse_pkg::*;

    localparam int TABLE_SIZE   = 1021;
    localparam int SECOND_PRIME = 97;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic                 found;
        logic                 inserted;
        logic                 table_full;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 set_empty;
    } t_keyset_result;

    class keyset_scoreboard;
        logic [KEY_IN_W-1:0]  slot_key [TABLE_SIZE];
        logic [ST_W-1:0]      slot_state [TABLE_SIZE];
        logic [CNT_OUT_W-1:0] key_total;
        t_keyset_result       awaited_results [$];
        int                   errors;

        function new();
            foreach (slot_state[i]) slot_state[i] = ST_EMPTY;
            key_total = '0;
            errors = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function t_keyset_result apply_request(logic [REQ_W-1:0] req,
                                               logic [KEY_IN_W-1:0] key);
            int pos;
            int step;
            int tomb;
            int hit;
            int free_slot;
            bit ended;
            t_keyset_result r;
            r = '0;
            if (req == REQ_ADD || req == REQ_REMOVE || req == REQ_CONTAINS) begin
                pos = key % TABLE_SIZE;
                step = SECOND_PRIME - key % SECOND_PRIME;
                tomb = -1;
                hit = -1;
                free_slot = -1;
                ended = 1'b0;
                for (int i = 0; i < TABLE_SIZE && !ended; i++) begin
                    if (slot_state[pos] == ST_EMPTY) begin
                        free_slot = (tomb >= 0) ? tomb : pos;
                        ended = 1'b1;
                    end else if (slot_state[pos] == ST_USED) begin
                        if (slot_key[pos] == key) begin
                            hit = pos;
                            ended = 1'b1;
                        end
                    end else if (tomb < 0) begin
                        tomb = pos;
                    end
                    if (!ended) begin
                        pos += step;
                        if (pos >= TABLE_SIZE) pos -= TABLE_SIZE;
                    end
                end
                if (!ended) free_slot = tomb;
                r.found = (hit >= 0);
                if (req == REQ_ADD && hit < 0) begin
                    if (free_slot >= 0) begin
                        slot_key[free_slot] = key;
                        slot_state[free_slot] = ST_USED;
                        key_total++;
                        r.inserted = 1'b1;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end else if (req == REQ_REMOVE && hit >= 0) begin
                    slot_state[hit] = ST_TOMB;
                    if (key_total > 0) key_total--;
                end
            end
            r.entry_count = key_total;
            r.set_empty = (key_total == 0);
            return r;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [KEY_IN_W-1:0] key);
            awaited_results.push_back(apply_request(req, key));
        endfunction

        task report(string field, longint got, longint want);
            errors++;
            if (errors <= 200)
                $display("mismatch at %0t on %s: got %0d, expected %0d",
                         $realtime, field, got, want);
        endtask

        task check_result(logic found, logic inserted, logic table_full,
                          logic [CNT_OUT_W-1:0] entry_count, logic set_empty);
            t_keyset_result want;
            if (awaited_results.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            want = awaited_results.pop_front();
            if (found !== want.found) report("found", found, want.found);
            if (inserted !== want.inserted) report("inserted", inserted, want.inserted);
            if (table_full !== want.table_full)
                report("table_full", table_full, want.table_full);
            if (entry_count !== want.entry_count)
                report("entry_count", entry_count, want.entry_count);
            if (set_empty !== want.set_empty) report("set_empty", set_empty, want.set_empty);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [REQ_W-1:0]     i_req_type = REQ_ADD;
    logic [KEY_IN_W-1:0]  i_key = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_found;
    logic                 o_inserted;
    logic                 o_table_full;
    logic [CNT_OUT_W-1:0] o_entry_count;
    logic                 o_set_empty;

    keyset_scoreboard     sb;
    int                   items_sent = 0;
    int                   idle_phase = 0;
    int                   stall_hold = 0;
    bit                   hold_done = 1'b0;
    int                   quiet_cycles = 0;
    logic [KEY_IN_W-1:0]  key_pool [32];
    logic [KEY_IN_W-1:0]  filled_keys [$];

    double_hash_set_engine_unit #(
        .TABLE_SIZE   (TABLE_SIZE),
        .SECOND_PRIME (SECOND_PRIME),
        .KEY_WIDTH    (KEY_IN_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_inserted    (o_inserted),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count),
        .o_set_empty   (o_set_empty)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(o_found, o_inserted, o_table_full, o_entry_count,
                                o_set_empty);
            if (i_valid && !o_stall) sb.note_request(i_req_type, i_key);
        end
    end

    // receiver side: long hold-off once, else random stalls per phase
    always @(posedge i_clk) begin
        if (!hold_done && items_sent >= 300) begin
            hold_done = 1'b1;
            stall_hold = HOLD_CYCLES;
        end
        if (stall_hold > 0) begin
            stall_hold--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < (idle_phase == 0 ? 49 :
                                               idle_phase == 1 ? 26 : 0));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** double_hash_set_engine_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [KEY_IN_W-1:0] key);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 26 : (idle_phase == 1) ? 49 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_key <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        idle_phase = (items_sent < 400) ? 0 : (items_sent < 800) ? 1 : 2;
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [REQ_W-1:0] pick_request(int add_pct, int rem_pct, int con_pct);
        int r;
        r = $urandom_range(99);
        if (r < add_pct) return REQ_ADD;
        if (r < add_pct + rem_pct) return REQ_REMOVE;
        if (r < add_pct + rem_pct + con_pct) return REQ_CONTAINS;
        return REQ_UNUSED;
    endfunction

    initial begin
        logic [REQ_W-1:0]    req;
        logic [KEY_IN_W-1:0] k;
        int                  h1;
        int                  h2;
        sb = new();
        h1 = $urandom_range(TABLE_SIZE - 1);
        h2 = $urandom_range(TABLE_SIZE * SECOND_PRIME - 1);
        // pool: random keys, shared home slot, shared home slot and step, small keys
        for (int n = 0; n < 32; n++) begin
            case (n % 4)
                0: key_pool[n] = $urandom;
                1: key_pool[n] = h1 + $urandom_range(4000000) * TABLE_SIZE;
                2: key_pool[n] = h2 + $urandom_range(43000) * (TABLE_SIZE * SECOND_PRIME);
                default: key_pool[n] = n;
            endcase
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unused selector, extremes
        send_request(REQ_CONTAINS, 32'd0);
        send_request(REQ_REMOVE, 32'd0);
        send_request(REQ_UNUSED, 32'd0);
        send_request(REQ_ADD, 32'd0);
        send_request(REQ_ADD, 32'd0);
        send_request(REQ_ADD, 32'hFFFF_FFFF);
        send_request(REQ_CONTAINS, 32'hFFFF_FFFF);
        // probe chain on slot zero, tombstone skipped then reused
        send_request(REQ_ADD, 32'd1021);
        send_request(REQ_ADD, 32'd2042);
        send_request(REQ_REMOVE, 32'd1021);
        send_request(REQ_CONTAINS, 32'd2042);
        send_request(REQ_ADD, 32'd3063);
        send_request(REQ_CONTAINS, 32'd1021);
        send_request(REQ_REMOVE, 32'd0);
        send_request(REQ_REMOVE, 32'd0);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF);
        // same home slot and same step
        send_request(REQ_ADD, 32'd99037);
        send_request(REQ_ADD, 32'd198074);
        send_request(REQ_REMOVE, 32'd99037);
        send_request(REQ_CONTAINS, 32'd198074);
        send_request(REQ_UNUSED, 32'h5555_5555);
        send_request(REQ_CONTAINS, 32'hAAAA_AAAA);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
        wait_all_results();

        repeat (100) begin
            req = pick_request(40, 30, 25);
            send_request(req, key_pool[$urandom_range(31)]);
        end
        foreach (key_pool[n]) send_request(REQ_REMOVE, key_pool[n]);
        wait_all_results();

        // fill until adds run out of slots
        repeat (TABLE_SIZE) begin
            k = $urandom;
            filled_keys.push_back(k);
            send_request(REQ_ADD, k);
        end

        // crowded table: tombstones, long probe paths, full adds
        repeat (50) begin
            req = pick_request(20, 35, 40);
            if (req == REQ_REMOVE || (req == REQ_CONTAINS && $urandom_range(99) < 60))
                k = filled_keys[$urandom_range(filled_keys.size() - 1)];
            else
                k = $urandom;
            send_request(req, k);
        end

        wait_all_results();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("** double_hash_set_engine_unit: PASSED **");
        end else begin
            $display("** double_hash_set_engine_unit: FAILED **");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/dhse_pkg.sv
rtl/dhse_dp.sv
rtl/dhse_ctrl.sv
rtl/double_hash_set_engine_unit.sv
tb/tb.sv
